[sv/bvm_pkg.sv]
`timescale 1ns / 1ps

package bvm_pkg;

    // Widths of the datapath
    localparam int unsigned OHMS_W = 20;
    localparam int unsigned MV_W   = 16;
    localparam int unsigned CV_W   = 13;
    localparam int unsigned PCT_W  = 8;
    localparam int unsigned QUOT_W = 16;
    localparam int unsigned RDG_W  = 15;   // magnitude bits of a clamped reading
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_OHMS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_OHMS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV    = 3'd4;

    // Register values after reset
    localparam logic [OHMS_W-1:0] RST_FULL_OHMS  = 20'd110000;
    localparam logic [OHMS_W-1:0] RST_OUT_OHMS   = 20'd10000;
    localparam logic [MV_W-1:0]   RST_LOW_THRESH = 16'd14000;
    localparam logic [MV_W-1:0]   RST_EMPTY_MV   = 16'd13200;
    localparam logic [MV_W-1:0]   RST_FULL_MV    = 16'd16800;

    // Sequencing and scaling constants
    localparam int unsigned MUL_STEPS = 15;
    localparam int unsigned DIV_STEPS = 16;
    localparam logic [MV_W-1:0]  MV_SAT     = 16'hFFFF;
    localparam logic [15:0]      CV_RECIP   = 16'hCCCD;  // ceil(2^19 / 10)
    localparam int unsigned      CV_SHIFT   = 19;
    localparam logic [6:0]       PCT_SCALE  = 7'd100;
    localparam logic signed [PCT_W-1:0] PCT_FULL = 8'sd100;
    localparam logic signed [PCT_W-1:0] PCT_ZERO = 8'sd0;
    localparam logic signed [PCT_W-1:0] PCT_NONE = -8'sd1;

    // Input beat
    typedef struct packed {
        logic signed [15:0] adc_millivolts;
        logic               read_ok;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [MV_W-1:0]         batt_mv;
        logic [CV_W-1:0]         batt_cv;
        logic signed [PCT_W-1:0] charge_pct;
        logic                    sample_valid;
        logic                    low_flag;
        logic                    low_event;
    } t_out_beat;

    // Divider control
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

[sv/bvm_serial_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per step.
// Load with the dividend's high part (must be below the divisor) and its low
// 16 bits; after 16 steps the quotient sits in o_quot.
module bvm_serial_div (
    input  logic                             i_clk,
    input  bvm_pkg::t_div_ctl                i_ctl,
    input  logic [bvm_pkg::OHMS_W-1:0]       i_rem_init,
    input  logic [bvm_pkg::QUOT_W-1:0]       i_num_lo,
    input  logic [bvm_pkg::OHMS_W-1:0]       i_divisor,
    output logic [bvm_pkg::QUOT_W-1:0]       o_quot
);

    logic [bvm_pkg::OHMS_W-1:0] r_rem;
    logic [bvm_pkg::QUOT_W-1:0] r_dq;     // dividend bits out, quotient bits in
    logic [bvm_pkg::OHMS_W-1:0] r_dvs;

    logic [bvm_pkg::OHMS_W:0]   w_trial;
    logic [bvm_pkg::OHMS_W:0]   w_diff;
    logic                       w_ge;

    // Trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_dq[bvm_pkg::QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_rem_init;
            r_dq  <= i_num_lo;
            r_dvs <= i_divisor;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? w_diff[bvm_pkg::OHMS_W-1:0] : w_trial[bvm_pkg::OHMS_W-1:0];
            r_dq  <= {r_dq[bvm_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_quot = r_dq;

endmodule

[sv/battery_low_voltage_monitor_core.sv]
`timescale 1ns / 1ps

// Sequence: a good read runs a 15-step serial multiply, a 16-step scale divide
// and, only between the empty and full levels, a 16-step percent divide before
// the result is valid; a saturated read skips the scale divide, a failed read
// skips both; the result then waits while the result register stays full.
// One beat at a time: the next is accepted only after the result is loaded.
// Reset: synchronous, active low; registers go to defaults, state is cleared.
module battery_low_voltage_monitor_core #(
    parameter int unsigned DEBOUNCE_SAMPLES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bvm_pkg::t_in_beat                   i_in_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bvm_pkg::t_out_beat                  o_out_data,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bvm_pkg::OHMS_W-1:0]          i_cfg_data
);

    localparam int unsigned SW = $clog2(DEBOUNCE_SAMPLES + 1);
    localparam logic [SW-1:0] DEB = SW'(DEBOUNCE_SAMPLES);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL     = 9'b000000010,
        S_CHK     = 9'b000000100,
        S_DIV_MV  = 9'b000001000,
        S_UPDATE  = 9'b000010000,
        S_PCT     = 9'b000100000,
        S_DIV_PCT = 9'b001000000,
        S_PCT_END = 9'b010000000,
        S_FINISH  = 9'b100000000
    } t_state;

    // configuration registers
    logic [bvm_pkg::OHMS_W-1:0] r_full_ohms;
    logic [bvm_pkg::OHMS_W-1:0] r_out_ohms;
    logic [bvm_pkg::MV_W-1:0]   r_low_thresh;
    logic [bvm_pkg::MV_W-1:0]   r_empty_mv;
    logic [bvm_pkg::MV_W-1:0]   r_full_mv;

    // sequencer and monitor state
    t_state                     r_state,  n_state;
    logic [3:0]                 r_cnt,    n_cnt;
    logic [bvm_pkg::MV_W-1:0]   r_last_mv, n_last_mv;
    logic                       r_have,   n_have;
    logic                       r_low,    n_low;
    logic                       r_event,  n_event;
    logic [SW-1:0]              r_below,  n_below;
    logic [SW-1:0]              r_above,  n_above;
    logic                       r_out_valid, n_out_valid;

    // payload registers
    logic [bvm_pkg::OHMS_W-1:0] r_mh,  n_mh;     // product high part
    logic [bvm_pkg::RDG_W-1:0]  r_ml,  n_ml;     // multiplier / product low part
    logic                       r_sat, n_sat;
    logic [bvm_pkg::CV_W-1:0]   r_cv,  n_cv;
    logic signed [bvm_pkg::PCT_W-1:0] r_pct, n_pct;
    bvm_pkg::t_out_beat         r_out, n_out;

    // datapath wires
    logic                       w_in_acc;
    logic [bvm_pkg::OHMS_W:0]   w_mul_sum;
    logic [bvm_pkg::MV_W-1:0]   w_mv_new;
    logic [SW-1:0]              w_below_inc;
    logic [SW-1:0]              w_above_inc;
    logic [31:0]                w_cv_prod;
    logic [bvm_pkg::MV_W-1:0]   w_pct_diff;
    logic [22:0]                w_pct_num;
    logic [bvm_pkg::QUOT_W-1:0] w_quot;
    bvm_pkg::t_div_ctl          w_div_ctl;
    logic [bvm_pkg::OHMS_W-1:0] w_div_rem;
    logic [bvm_pkg::QUOT_W-1:0] w_div_lo;
    logic [bvm_pkg::OHMS_W-1:0] w_div_dvs;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // shift-add multiply step: add when the current multiplier bit is set
    assign w_mul_sum = {1'b0, r_mh} + (r_ml[0] ? {1'b0, r_full_ohms} : '0);

    assign w_mv_new    = r_sat ? bvm_pkg::MV_SAT : w_quot;
    assign w_below_inc = (r_below < DEB) ? r_below + SW'(1) : r_below;
    assign w_above_inc = (r_above < DEB) ? r_above + SW'(1) : r_above;

    // mV to cV by reciprocal multiply, exact over 16 bits
    assign w_cv_prod  = {16'd0, r_last_mv} * {16'd0, bvm_pkg::CV_RECIP};
    assign w_pct_diff = r_last_mv - r_empty_mv;
    assign w_pct_num  = {7'd0, w_pct_diff} * 23'(bvm_pkg::PCT_SCALE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last_mv   = r_last_mv;
        n_have      = r_have;
        n_low       = r_low;
        n_event     = r_event;
        n_below     = r_below;
        n_above     = r_above;
        n_out_valid = r_out_valid;
        n_mh        = r_mh;
        n_ml        = r_ml;
        n_sat       = r_sat;
        n_cv        = r_cv;
        n_pct       = r_pct;
        n_out       = r_out;
        w_div_ctl   = '0;
        w_div_rem   = {1'b0, r_mh[bvm_pkg::OHMS_W-1:1]};
        w_div_lo    = {r_mh[0], r_ml};
        w_div_dvs   = r_out_ohms;

        // output beat taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_event = 1'b0;
                    if (i_in_data.read_ok) begin
                        n_mh    = '0;
                        n_ml    = i_in_data.adc_millivolts[15] ? '0 :
                                  i_in_data.adc_millivolts[bvm_pkg::RDG_W-1:0];
                        n_cnt   = 4'(bvm_pkg::MUL_STEPS - 1);
                        n_state = S_MUL;
                    end else begin
                        n_state = S_PCT;
                    end
                end
            end
            S_MUL: begin
                n_mh = w_mul_sum[bvm_pkg::OHMS_W:1];
                n_ml = {w_mul_sum[0], r_ml[bvm_pkg::RDG_W-1:1]};
                if (r_cnt == 4'd0) begin
                    n_state = S_CHK;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_CHK: begin
                // quotient overflows 16 bits (or divisor is zero): saturate
                if ({1'b0, r_mh[bvm_pkg::OHMS_W-1:1]} >= r_out_ohms) begin
                    n_sat   = 1'b1;
                    n_state = S_UPDATE;
                end else begin
                    n_sat          = 1'b0;
                    w_div_ctl.load = 1'b1;
                    n_cnt          = 4'(bvm_pkg::DIV_STEPS - 1);
                    n_state        = S_DIV_MV;
                end
            end
            S_DIV_MV: begin
                w_div_ctl.step = 1'b1;
                if (r_cnt == 4'd0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_UPDATE: begin
                // store the sample and run the debounce counters
                n_last_mv = w_mv_new;
                n_have    = 1'b1;
                if (w_mv_new < r_low_thresh) begin
                    n_above = '0;
                    n_below = w_below_inc;
                    if (!r_low && (w_below_inc >= DEB)) begin
                        n_low   = 1'b1;
                        n_event = 1'b1;
                    end
                end else begin
                    n_below = '0;
                    n_above = w_above_inc;
                    if (r_low && (w_above_inc >= DEB)) begin
                        n_low = 1'b0;
                    end
                end
                n_state = S_PCT;
            end
            S_PCT: begin
                n_cv = w_cv_prod[bvm_pkg::CV_SHIFT +: bvm_pkg::CV_W];
                if (!r_have || (r_last_mv <= r_empty_mv)) begin
                    n_pct   = bvm_pkg::PCT_ZERO;
                    n_state = S_FINISH;
                end else if (r_last_mv >= r_full_mv) begin
                    n_pct   = bvm_pkg::PCT_FULL;
                    n_state = S_FINISH;
                end else begin
                    w_div_rem      = {13'd0, w_pct_num[22:16]};
                    w_div_lo       = w_pct_num[15:0];
                    w_div_dvs      = {4'd0, r_full_mv - r_empty_mv};
                    w_div_ctl.load = 1'b1;
                    n_cnt          = 4'(bvm_pkg::DIV_STEPS - 1);
                    n_state        = S_DIV_PCT;
                end
            end
            S_DIV_PCT: begin
                w_div_ctl.step = 1'b1;
                if (r_cnt == 4'd0) begin
                    n_state = S_PCT_END;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_PCT_END: begin
                n_pct   = w_quot[bvm_pkg::PCT_W-1:0];
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.batt_mv       = r_last_mv;
                    n_out.batt_cv       = r_have ? r_cv : '0;
                    n_out.charge_pct    = r_have ? r_pct : bvm_pkg::PCT_NONE;
                    n_out.sample_valid  = r_have;
                    n_out.low_flag      = r_low;
                    n_out.low_event     = r_event;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    bvm_serial_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_rem_init (w_div_rem),
        .i_num_lo   (w_div_lo),
        .i_divisor  (w_div_dvs),
        .o_quot     (w_quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last_mv   <= '0;
            r_have      <= 1'b0;
            r_low       <= 1'b0;
            r_event     <= 1'b0;
            r_below     <= '0;
            r_above     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last_mv   <= n_last_mv;
            r_have      <= n_have;
            r_low       <= n_low;
            r_event     <= n_event;
            r_below     <= n_below;
            r_above     <= n_above;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mh  <= n_mh;
        r_ml  <= n_ml;
        r_sat <= n_sat;
        r_cv  <= n_cv;
        r_pct <= n_pct;
        r_out <= n_out;
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_ohms  <= bvm_pkg::RST_FULL_OHMS;
            r_out_ohms   <= bvm_pkg::RST_OUT_OHMS;
            r_low_thresh <= bvm_pkg::RST_LOW_THRESH;
            r_empty_mv   <= bvm_pkg::RST_EMPTY_MV;
            r_full_mv    <= bvm_pkg::RST_FULL_MV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bvm_pkg::CFG_FULL_OHMS:  r_full_ohms  <= i_cfg_data;
                bvm_pkg::CFG_OUT_OHMS:   r_out_ohms   <= i_cfg_data;
                bvm_pkg::CFG_LOW_THRESH: r_low_thresh <= i_cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_EMPTY_MV:   r_empty_mv   <= i_cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_FULL_MV:    r_full_mv    <= i_cfg_data[bvm_pkg::MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("sequencer did not leave idle after an accepted beat");

    a_streak_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_below != '0) && (r_above != '0)))
        else $error("below and above streaks both running");

    a_streak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_below <= DEB) && (r_above <= DEB))
        else $error("streak counter past debounce length");

    a_event_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.low_event) |-> o_out_data.low_flag)
        else $error("low event without low flag");

    a_pct_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.sample_valid == (o_out_data.charge_pct != bvm_pkg::PCT_NONE)))
        else $error("percent marker disagrees with sample valid");

endmodule
